/* hw/rtl/tcc_pkg.sv */
`default_nettype none
package tcc_pkg;

    // Field and register widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int IN_COL_W   = 7;
    localparam int IN_ROW_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COLS_REG_W = 8;
    localparam int ROWS_REG_W = 7;
    localparam int TAB_W      = 8;
    localparam int STATUS_W   = 2;

    // Register reset values
    localparam logic [COLS_REG_W-1:0] COLS_RST = 8'd80;
    localparam logic [ROWS_REG_W-1:0] ROWS_RST = 7'd25;
    localparam logic [TAB_W-1:0]      TAB_RST  = 8'd8;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    typedef enum logic [OP_W-1:0] {
        OP_PUT  = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_TAB     = 2'd2,
        CFG_ENABLE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_UNSUP = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CC_PRINT,
        CC_BELL,
        CC_UNSUP,
        CC_FF,
        CC_LF,
        CC_CR,
        CC_TAB
    } t_char_cls;

    typedef enum logic [2:0] {
        S_RST_CLR,
        S_IDLE,
        S_DECODE,
        S_FF_CLR,
        S_LINE_CLR,
        S_TAB_MOD,
        S_TAB_PUT,
        S_OUT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;
        logic sweep_rst;
        logic clr_all_step;
        logic line_step;
        logic put;
        logic put_blank;
        logic newline;
        logic cr;
        logic home;
        logic set_cur;
        logic rd_cell;
        logic bell;
        logic unsup;
        logic mod_load;
        logic mod_sub;
        logic mod_inc;
        logic out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_op       op;
        t_char_cls cls;
        logic      enabled;
        logic      wrap;
        logic      all_last;
        logic      line_last;
        logic      mod_ge_tab;
        logic      mod_zero;
        logic      mod_next_zero;
        logic      out_free;
    } t_sts;

endpackage
`default_nettype wire

/* hw/rtl/text_console_char_buffer_top.sv */
// After the input transfer an item passes the decode state, then the output state, which loads
// the result register once it is free. Newline or line wrap adds a sweep over the MAX_COLUMNS
// cells of the new line; form feed sweeps all 2**(row bits + column bits) store cells (8192 by default).
// Tab: decode writes the first space; the tab-phase state reduces the next column modulo the tab size,
// then one space is written per step up to the next tab stop; a new item is taken only in idle.
// Reset (i_rst_n low, synchronous) clears control state, then runs a blanking pass over the whole store.
`default_nettype none
module text_console_char_buffer_top
    import tcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input item channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [IN_COL_W-1:0]   i_column,
    input  wire logic [IN_ROW_W-1:0]   i_row,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [CHAR_W-1:0]          o_cell_char,
    output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] o_cursor_column,
    output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0]       o_cursor_row,
    output logic [$clog2(MAX_ROWS + 1)-1:0]                          o_rows_filled,
    output logic                       o_bell,
    output logic [STATUS_W-1:0]        o_status
);

    // Cursor and ring widths follow the screen maximums.
    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    t_cmd cmd;
    t_sts sts;

    // Register writes must be issued only while the console is quiet; the
    // block does not enforce it. The write channel never stalls. A write to
    // the column or row count pulls the cursor into the new area on the following cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer: decodes each captured item and steps the datapath through
    // store writes, line/screen blanking sweeps and the tab-stop loop.
    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: configuration, cursor, scroll offset, character store and
    // the result register. The result register holds a finished transfer
    // while the next item is captured and worked on.
    tcc_dpath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .COL_W       (COL_W),
        .ROW_W       (ROW_W),
        .CNT_W       (CNT_W)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_operation),
        .i_char_code     (i_char_code),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_cell_char     (o_cell_char),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_rows_filled   (o_rows_filled),
        .o_bell          (o_bell),
        .o_status        (o_status)
    );

endmodule
`default_nettype wire

/* hw/rtl/tcc_ram.sv */
`default_nettype none
module tcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hw/rtl/tcc_ctrl.sv */
`default_nettype none
module tcc_ctrl
    import tcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RST_CLR: begin
                if (i_sts.all_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = S_OUT;
                if (i_sts.op == OP_PUT && i_sts.enabled) begin
                    case (i_sts.cls)
                        CC_FF:    n_state = S_FF_CLR;
                        CC_LF:    n_state = S_LINE_CLR;
                        CC_TAB:   n_state = i_sts.wrap ? S_LINE_CLR : S_TAB_MOD;
                        CC_PRINT: n_state = i_sts.wrap ? S_LINE_CLR : S_OUT;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_FF_CLR: begin
                if (i_sts.all_last) n_state = S_OUT;
            end
            S_LINE_CLR: begin
                if (i_sts.line_last) n_state = S_OUT;
            end
            S_TAB_MOD: begin
                if (!i_sts.mod_ge_tab) begin
                    n_state = i_sts.mod_zero ? S_OUT : S_TAB_PUT;
                end
            end
            S_TAB_PUT: begin
                if (i_sts.wrap) begin
                    n_state = S_LINE_CLR;
                end else if (i_sts.mod_next_zero) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_RST_CLR: begin
                o_cmd.clr_all_step = 1'b1;
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_PUT: begin
                        if (i_sts.enabled) begin
                            case (i_sts.cls)
                                CC_BELL:  o_cmd.bell = 1'b1;
                                CC_UNSUP: o_cmd.unsup = 1'b1;
                                CC_FF: begin
                                    o_cmd.home      = 1'b1;
                                    o_cmd.sweep_rst = 1'b1;
                                end
                                CC_LF: begin
                                    o_cmd.newline   = 1'b1;
                                    o_cmd.sweep_rst = 1'b1;
                                end
                                CC_CR:    o_cmd.cr = 1'b1;
                                CC_TAB: begin
                                    o_cmd.put       = 1'b1;
                                    o_cmd.put_blank = 1'b1;
                                    o_cmd.mod_load  = 1'b1;
                                    o_cmd.sweep_rst = 1'b1;
                                end
                                default: begin
                                    o_cmd.put       = 1'b1;
                                    o_cmd.sweep_rst = 1'b1;
                                end
                            endcase
                        end
                    end
                    OP_SET:  o_cmd.set_cur = 1'b1;
                    OP_READ: o_cmd.rd_cell = 1'b1;
                    OP_NONE: o_cmd.load_in = 1'b0;
                    default: o_cmd.load_in = 1'b0;
                endcase
            end
            S_FF_CLR: begin
                o_cmd.clr_all_step = 1'b1;
            end
            S_LINE_CLR: begin
                o_cmd.line_step = 1'b1;
            end
            S_TAB_MOD: begin
                o_cmd.mod_sub = i_sts.mod_ge_tab;
            end
            S_TAB_PUT: begin
                o_cmd.put       = 1'b1;
                o_cmd.put_blank = 1'b1;
                o_cmd.mod_inc   = 1'b1;
                o_cmd.sweep_rst = 1'b1;
            end
            S_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/tcc_dpath.sv */
`default_nettype none
module tcc_dpath
    import tcc_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int COL_W       = 7,
    parameter int ROW_W       = 6,
    parameter int CNT_W       = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [IN_COL_W-1:0]   i_column,
    input  wire logic [IN_ROW_W-1:0]   i_row,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic      [CHAR_W-1:0]     o_cell_char,
    output logic      [COL_W-1:0]      o_cursor_column,
    output logic      [ROW_W-1:0]      o_cursor_row,
    output logic      [CNT_W-1:0]      o_rows_filled,
    output logic                       o_bell,
    output logic      [STATUS_W-1:0]   o_status
);

    localparam int ECOL_W = $clog2(MAX_COLUMNS + 1);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int SUM_W  = ROW_W + 1;

    // Ring mapping: displayed row -> physical line
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                  input logic [ROW_W-1:0] r);
        logic [SUM_W-1:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= SUM_W'(MAX_ROWS)) s = s - SUM_W'(MAX_ROWS);
        return s[ROW_W-1:0];
    endfunction

    // Configuration
    logic [COLS_REG_W-1:0] r_cols;
    logic [ROWS_REG_W-1:0] r_rows;
    logic [TAB_W-1:0]      r_tab;
    logic                  r_enabled;
    logic                  r_clamp;

    // Console state
    logic [COL_W-1:0]  r_cur_col,  n_cur_col;
    logic [ROW_W-1:0]  r_cur_line, n_cur_line;
    logic [ROW_W-1:0]  r_top,      n_top;
    logic [CNT_W-1:0]  r_used,     n_used;
    logic [COL_W-1:0]  r_mod,      n_mod;
    logic              r_cell_ok,  n_cell_ok;
    logic              r_bell,     n_bell;
    t_status           r_status,   n_status;
    logic [ADDR_W-1:0] r_sweep;

    // Captured item
    logic [OP_W-1:0]     r_op;
    logic [CHAR_W-1:0]   r_ch;
    logic [IN_COL_W-1:0] r_col;
    logic [IN_ROW_W-1:0] r_row;

    // Result register
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_cell;
    logic [COL_W-1:0]    r_out_col;
    logic [ROW_W-1:0]    r_out_row;
    logic [CNT_W-1:0]    r_out_used;
    logic                r_out_bell;
    t_status             r_out_status;

    logic [ECOL_W-1:0] eff_cols;
    logic [CNT_W-1:0]  eff_rows;
    logic [TAB_W-1:0]  eff_tab;
    logic [ECOL_W-1:0] col_inc;
    logic              wrap;
    logic [CNT_W-1:0]  line_inc;
    logic              nl_scroll;
    logic [ROW_W-1:0]  nl_line;
    logic [ROW_W-1:0]  nl_top;
    logic [CNT_W-1:0]  nl_need;
    logic [CNT_W-1:0]  set_need;
    logic              rng_bad;
    logic [8:0]        mod_inc;
    logic [ROW_W-1:0]  cur_phys;
    t_char_cls         cls;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    // Effective geometry
    always_comb begin
        if (r_cols == '0) begin
            eff_cols = ECOL_W'(1);
        end else if (32'(r_cols) > MAX_COLUMNS) begin
            eff_cols = ECOL_W'(MAX_COLUMNS);
        end else begin
            eff_cols = ECOL_W'(r_cols);
        end
        if (r_rows == '0) begin
            eff_rows = CNT_W'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            eff_rows = CNT_W'(MAX_ROWS);
        end else begin
            eff_rows = CNT_W'(r_rows);
        end
        eff_tab = (r_tab == '0) ? TAB_W'(1) : r_tab;
    end

    assign col_inc   = ECOL_W'(r_cur_col) + 1'b1;
    assign wrap      = col_inc >= eff_cols;
    assign line_inc  = CNT_W'(r_cur_line) + 1'b1;
    assign nl_scroll = line_inc >= eff_rows;
    assign nl_line   = nl_scroll ? ROW_W'(eff_rows - 1'b1) : ROW_W'(line_inc);
    assign nl_top    = !nl_scroll ? r_top :
                       (r_top == ROW_W'(MAX_ROWS - 1)) ? '0 : r_top + 1'b1;
    assign nl_need   = CNT_W'(nl_line) + 1'b1;
    assign set_need  = CNT_W'(r_row) + 1'b1;
    assign rng_bad   = (32'(r_col) >= 32'(eff_cols)) || (32'(r_row) >= 32'(eff_rows));
    assign mod_inc   = 9'(r_mod) + 1'b1;
    assign cur_phys  = phys_row(r_top, r_cur_line);

    always_comb begin
        case (r_ch)
            CH_BELL:      cls = CC_BELL;
            CH_BS, CH_VT: cls = CC_UNSUP;
            CH_FF:        cls = CC_FF;
            CH_LF:        cls = CC_LF;
            CH_CR:        cls = CC_CR;
            CH_TAB:       cls = CC_TAB;
            default:      cls = CC_PRINT;
        endcase
    end

    always_comb begin
        o_sts.op            = t_op'(r_op);
        o_sts.cls           = cls;
        o_sts.enabled       = r_enabled;
        o_sts.wrap          = wrap;
        o_sts.all_last      = &r_sweep;
        o_sts.line_last     = r_sweep[COL_W-1:0] == COL_W'(MAX_COLUMNS - 1);
        o_sts.mod_ge_tab    = 9'(r_mod) >= 9'(eff_tab);
        o_sts.mod_zero      = r_mod == '0;
        o_sts.mod_next_zero = mod_inc == 9'(eff_tab);
        o_sts.out_free      = !r_out_valid || i_out_ready;
    end

    // Next console state
    always_comb begin
        n_cur_col  = r_cur_col;
        n_cur_line = r_cur_line;
        n_top      = r_top;
        n_used     = r_used;
        n_mod      = r_mod;
        n_cell_ok  = r_cell_ok;
        n_bell     = r_bell;
        n_status   = r_status;

        // pull cursor and line count back inside a shrunk screen
        if (r_clamp) begin
            if (ECOL_W'(r_cur_col) >= eff_cols) n_cur_col = COL_W'(eff_cols - 1'b1);
            if (CNT_W'(r_cur_line) >= eff_rows) n_cur_line = ROW_W'(eff_rows - 1'b1);
            if (r_used > eff_rows) n_used = eff_rows;
        end
        if (i_cmd.load_in) begin
            n_cell_ok = 1'b0;
            n_bell    = 1'b0;
            n_status  = ST_OK;
        end
        if (i_cmd.home) begin
            n_top      = '0;
            n_cur_col  = '0;
            n_cur_line = '0;
            n_used     = CNT_W'(1);
        end
        if (i_cmd.newline || (i_cmd.put && wrap)) begin
            n_cur_col  = '0;
            n_cur_line = nl_line;
            n_top      = nl_top;
            if (nl_need > r_used) n_used = nl_need;
        end else if (i_cmd.put) begin
            n_cur_col = COL_W'(col_inc);
        end
        if (i_cmd.cr) n_cur_col = '0;
        if (i_cmd.set_cur) begin
            if (rng_bad) begin
                n_status = ST_RANGE;
            end else begin
                n_cur_col  = COL_W'(r_col);
                n_cur_line = ROW_W'(r_row);
                if (set_need > r_used) n_used = set_need;
            end
        end
        if (i_cmd.rd_cell) begin
            if (rng_bad) n_status = ST_RANGE;
            else n_cell_ok = 1'b1;
        end
        if (i_cmd.bell) n_bell = 1'b1;
        if (i_cmd.unsup) n_status = ST_UNSUP;
        if (i_cmd.mod_load) n_mod = COL_W'(col_inc);
        if (i_cmd.mod_sub) n_mod = COL_W'(9'(r_mod) - 9'(eff_tab));
        if (i_cmd.mod_inc) n_mod = (mod_inc == 9'(eff_tab)) ? '0 : COL_W'(mod_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= COLS_RST;
            r_rows      <= ROWS_RST;
            r_tab       <= TAB_RST;
            r_enabled   <= 1'b1;
            r_clamp     <= 1'b0;
            r_cur_col   <= '0;
            r_cur_line  <= '0;
            r_top       <= '0;
            r_used      <= CNT_W'(1);
            r_mod       <= '0;
            r_cell_ok   <= 1'b0;
            r_bell      <= 1'b0;
            r_status    <= ST_OK;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clamp <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_COLUMNS: begin
                        r_cols  <= i_cfg_data[COLS_REG_W-1:0];
                        r_clamp <= 1'b1;
                    end
                    CFG_ROWS: begin
                        r_rows  <= i_cfg_data[ROWS_REG_W-1:0];
                        r_clamp <= 1'b1;
                    end
                    CFG_TAB:    r_tab <= i_cfg_data[TAB_W-1:0];
                    CFG_ENABLE: r_enabled <= i_cfg_data[0];
                    default:    r_tab <= r_tab;
                endcase
            end
            r_cur_col  <= n_cur_col;
            r_cur_line <= n_cur_line;
            r_top      <= n_top;
            r_used     <= n_used;
            r_mod      <= n_mod;
            r_cell_ok  <= n_cell_ok;
            r_bell     <= n_bell;
            r_status   <= n_status;
            if (i_cmd.sweep_rst) begin
                r_sweep <= '0;
            end else if (i_cmd.clr_all_step || i_cmd.line_step) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_operation;
            r_ch  <= i_char_code;
            r_col <= i_column;
            r_row <= i_row;
        end
        if (i_cmd.out_load) begin
            r_out_cell   <= r_cell_ok ? ram_rdata : '0;
            r_out_col    <= r_cur_col;
            r_out_row    <= r_cur_line;
            r_out_used   <= r_used;
            r_out_bell   <= r_bell;
            r_out_status <= r_status;
        end
    end

    // Memory ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {cur_phys, r_cur_col};
        ram_wdata = CH_BLANK;
        if (i_cmd.clr_all_step) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep;
        end else if (i_cmd.line_step) begin
            ram_we    = 1'b1;
            ram_waddr = {cur_phys, r_sweep[COL_W-1:0]};
        end else if (i_cmd.put) begin
            ram_we    = 1'b1;
            ram_wdata = i_cmd.put_blank ? CH_BLANK : r_ch;
        end
    end

    assign ram_re    = i_cmd.rd_cell && !rng_bad;
    assign ram_raddr = {phys_row(r_top, ROW_W'(r_row)), COL_W'(r_col)};

    tcc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_cell_char     = r_out_cell;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_rows_filled   = r_out_used;
    assign o_bell          = r_out_bell;
    assign o_status        = r_out_status;

endmodule
`default_nettype wire

/* test/testbench.sv */
module testbench;
    import tcc_pkg::*;

    localparam int MAX_COLS   = 128;
    localparam int MAX_LINES  = 64;
    localparam int CELLS      = MAX_COLS * MAX_LINES;
    localparam int CYCLE_CAP  = 3_000_000;   // timeout, well beyond the slowest legal run
    localparam int PRINT_CAP  = 60;          // mismatches past this are counted, not printed
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 180;

    // ------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_operation = '0;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic [IN_COL_W-1:0]   i_column    = '0;
    logic [IN_ROW_W-1:0]   i_row       = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [CHAR_W-1:0]     o_cell_char;
    logic [6:0]            o_cursor_column;
    logic [5:0]            o_cursor_row;
    logic [6:0]            o_rows_filled;
    logic                  o_bell;
    logic [STATUS_W-1:0]   o_status;

    text_console_char_buffer_top #(
        .MAX_COLUMNS(MAX_COLS),
        .MAX_ROWS   (MAX_LINES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_char_code    (i_char_code),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cell_char    (o_cell_char),
        .o_cursor_column(o_cursor_column),
        .o_cursor_row   (o_cursor_row),
        .o_rows_filled  (o_rows_filled),
        .o_bell         (o_bell),
        .o_status       (o_status)
    );

    // One result transfer as the console should report it
    typedef struct {
        logic [CHAR_W-1:0] glyph;
        logic [6:0]        col;
        logic [5:0]        row;
        logic [6:0]        filled;
        logic              bell;
        t_status           status;
    } console_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the screen ring, cursor and registers, and
    // queues the result each accepted item should produce.
    // ------------------------------------------------------------------
    class console_mirror;
        logic [CHAR_W-1:0] cells [CELLS];
        int unsigned       top_line, cur_col, cur_line, lines_used;
        logic [7:0]        cols_reg;
        logic [6:0]        rows_reg;
        logic [7:0]        tab_reg;
        logic              enable_reg;
        console_result_t   awaited[$];
        int unsigned       mismatches;

        function new();
            cols_reg   = COLS_RST;
            rows_reg   = ROWS_RST;
            tab_reg    = TAB_RST;
            enable_reg = 1'b1;
            mismatches = 0;
            clear_screen();
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endfunction

        // zero acts as one, oversize clamps to the physical size
        function int unsigned eff_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        function int unsigned eff_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_LINES) return MAX_LINES;
            return rows_reg;
        endfunction

        // displayed row r sits in physical line (top + r) mod MAX_LINES
        function int unsigned slot(int unsigned r, int unsigned c);
            return ((top_line + r) % MAX_LINES) * MAX_COLS + (c % MAX_COLS);
        endfunction

        function void clear_screen();
            foreach (cells[i]) cells[i] = CH_BLANK;
            top_line   = 0;
            cur_col    = 0;
            cur_line   = 0;
            lines_used = 1;
        endfunction

        // scroll when past the last row, then blank the whole new line
        function void new_line();
            int unsigned rows;
            rows     = eff_rows();
            cur_col  = 0;
            cur_line = cur_line + 1;
            if (cur_line >= rows) begin
                top_line = (top_line + 1) % MAX_LINES;
                cur_line = rows - 1;
            end
            if (lines_used < cur_line + 1) lines_used = cur_line + 1;
            for (int unsigned c = 0; c < MAX_COLS; c++) cells[slot(cur_line, c)] = CH_BLANK;
        endfunction

        function void store_char(logic [CHAR_W-1:0] ch);
            cells[slot(cur_line, cur_col)] = ch;
            cur_col++;
            if (cur_col >= eff_cols()) new_line();
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            logic shrink;
            shrink = 1'b0;
            case (idx)
                CFG_COLUMNS: begin
                    cols_reg = data;
                    shrink   = 1'b1;
                end
                CFG_ROWS: begin
                    rows_reg = data[6:0];
                    shrink   = 1'b1;
                end
                CFG_TAB:    tab_reg    = data;
                CFG_ENABLE: enable_reg = data[0];
                default: ;
            endcase
            // geometry writes pull the cursor and the used-line count inside
            if (shrink) begin
                if (cur_col >= eff_cols()) cur_col = eff_cols() - 1;
                if (cur_line >= eff_rows()) cur_line = eff_rows() - 1;
                if (lines_used > eff_rows()) lines_used = eff_rows();
            end
        endfunction

        function void take_item(t_op op, logic [CHAR_W-1:0] ch, logic [6:0] col,
                                logic [5:0] row);
            console_result_t r;
            int unsigned     tab;
            r.glyph  = '0;
            r.bell   = 1'b0;
            r.status = ST_OK;
            tab      = (tab_reg == 0) ? 1 : tab_reg;
            case (op)
                OP_PUT: begin
                    if (enable_reg) begin
                        case (ch)
                            CH_BELL:      r.bell = 1'b1;
                            CH_BS, CH_VT: r.status = ST_UNSUP;
                            CH_FF:        clear_screen();
                            CH_LF:        new_line();
                            CH_CR:        cur_col = 0;
                            CH_TAB: begin
                                store_char(CH_BLANK);
                                while ((cur_col % tab) != 0) store_char(CH_BLANK);
                            end
                            default:      store_char(ch);
                        endcase
                    end
                end
                OP_SET: begin
                    if (col >= eff_cols() || row >= eff_rows()) begin
                        r.status = ST_RANGE;
                    end else begin
                        cur_col  = col;
                        cur_line = row;
                        if (lines_used < row + 1) lines_used = row + 1;
                    end
                end
                OP_READ: begin
                    if (col >= eff_cols() || row >= eff_rows()) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.glyph = cells[slot(row, col)];
                    end
                end
                default: ;
            endcase
            r.col    = cur_col[6:0];
            r.row    = cur_line[5:0];
            r.filled = lines_used[6:0];
            awaited.push_back(r);
        endfunction

        function void check_result(logic [CHAR_W-1:0] glyph, logic [6:0] col, logic [5:0] row,
                                   logic [6:0] filled, logic bell,
                                   logic [STATUS_W-1:0] status);
            console_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending (cursor %0d,%0d)",
                                          col, row));
                return;
            end
            want = awaited.pop_front();
            if (glyph !== want.glyph)
                report_mismatch($sformatf("cell_char %h, want %h", glyph, want.glyph));
            if (col !== want.col)
                report_mismatch($sformatf("cursor_column %0d, want %0d", col, want.col));
            if (row !== want.row)
                report_mismatch($sformatf("cursor_row %0d, want %0d", row, want.row));
            if (filled !== want.filled)
                report_mismatch($sformatf("rows_filled %0d, want %0d", filled, want.filled));
            if (bell !== want.bell)
                report_mismatch($sformatf("bell %b, want %b", bell, want.bell));
            if (status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        endfunction
    endclass

    console_mirror board;
    int unsigned   send_idle_pct  = 0;   // chance per cycle the sender holds off
    int unsigned   recv_stall_pct = 0;   // chance per cycle the receiver stalls
    int unsigned   cycle_count    = 0;

    // 12-unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: ready changes on the falling edge, transfers are
    // taken at the rising edge
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_cell_char, o_cursor_column, o_cursor_row, o_rows_filled,
                               o_bell, o_status);
        end
    end

    // Drive one item. Entered right after a rising edge; the random gap
    // lowers valid, otherwise valid stays up straight into the next item.
    task automatic send_item(t_op op, logic [CHAR_W-1:0] ch, logic [6:0] col,
                             logic [5:0] row);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_char_code <= ch;
        i_column    <= col;
        i_row       <= row;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_item(op, ch, col, row);
    endtask

    // Drop input valid and hold off until every pending result is back
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // One register transfer; only called once the console is idle
    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Per-phase geometry: defaults, small, full size, one cell, oversize,
    // zero, disabled, and a random last phase.
    logic [7:0] phase_cols [PHASES] = '{8'd80, 8'd10, 8'd128, 8'd1, 8'd255, 8'd0, 8'd7, 8'd40};
    logic [7:0] phase_rows [PHASES] = '{8'd25, 8'd4, 8'd64, 8'd1, 8'd127, 8'd0, 8'd5, 8'd12};
    logic [7:0] phase_tab  [PHASES] = '{8'd8, 8'd3, 8'd128, 8'd0, 8'd255, 8'd1, 8'd4, 8'd5};
    logic [7:0] phase_en   [PHASES] = '{8'h01, 8'h01, 8'h01, 8'h01, 8'hFF, 8'h01, 8'hFE, 8'h01};

    initial begin
        int unsigned       pick;
        t_op               op;
        logic [CHAR_W-1:0] ch;
        logic [6:0]        col;
        logic [5:0]        row;

        board = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- directed part, default 80x25, tab 8 ----------------
        send_item(OP_PUT, 8'h41, 7'd0, 6'd0);
        send_item(OP_PUT, 8'hFF, 7'd127, 6'd63);   // top byte, ignored position bits high
        send_item(OP_PUT, 8'h00, 7'd0, 6'd0);      // zero byte is stored like any other
        send_item(OP_PUT, CH_TAB, 7'd0, 6'd0);
        send_item(OP_PUT, CH_BELL, 7'd0, 6'd0);
        send_item(OP_PUT, CH_BS, 7'd0, 6'd0);      // backspace: flagged, ignored
        send_item(OP_PUT, CH_VT, 7'd0, 6'd0);      // vertical tab: same
        send_item(OP_READ, 8'h00, 7'd0, 6'd0);
        send_item(OP_READ, 8'hFF, 7'd127, 6'd63);  // read outside the screen
        send_item(OP_SET, 8'h00, 7'd79, 6'd24);    // bottom right corner
        send_item(OP_PUT, 8'h5A, 7'd0, 6'd0);      // wraps on the last row -> scroll
        send_item(OP_PUT, CH_LF, 7'd0, 6'd0);      // second scroll
        send_item(OP_PUT, CH_CR, 7'd0, 6'd0);
        send_item(OP_SET, 8'h00, 7'd80, 6'd0);     // column one past the end
        send_item(OP_SET, 8'h00, 7'd0, 6'd25);     // row one past the end
        send_item(OP_NONE, 8'h5A, 7'd127, 6'd63);  // unused operation code
        send_item(OP_READ, 8'h00, 7'd79, 6'd22);   // the wrapped char, moved up two rows
        send_item(OP_PUT, CH_FF, 7'd0, 6'd0);      // clear screen
        send_item(OP_READ, 8'h00, 7'd0, 6'd0);

        // disabled console: puts do nothing, set and read still work
        settle();
        write_register(CFG_ENABLE, 8'hFE);
        send_item(OP_PUT, 8'h51, 7'd0, 6'd0);
        send_item(OP_PUT, CH_LF, 7'd0, 6'd0);
        send_item(OP_SET, 8'h00, 7'd70, 6'd20);
        send_item(OP_READ, 8'h00, 7'd0, 6'd0);

        // shrink to zero columns (acts as one), oversize rows, zero tab
        settle();
        write_register(CFG_ENABLE, 8'h01);
        write_register(CFG_COLUMNS, 8'h00);
        write_register(CFG_ROWS, 8'hFF);
        write_register(CFG_TAB, 8'h00);
        send_item(OP_PUT, CH_TAB, 7'd0, 6'd0);
        send_item(OP_PUT, 8'h42, 7'd0, 6'd0);

        // ---------------- random phases ----------------
        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == PHASES - 1) begin
                phase_cols[p] = 8'($urandom_range(2, 128));
                phase_rows[p] = 8'($urandom_range(2, 64));
                phase_tab[p]  = 8'($urandom_range(1, 16));
            end
            write_register(CFG_COLUMNS, phase_cols[p]);
            write_register(CFG_ROWS, phase_rows[p]);
            write_register(CFG_TAB, phase_tab[p]);
            write_register(CFG_ENABLE, phase_en[p]);

            // idle mix: none, sender heavy, receiver heavy, light on both
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase

            for (int n = 0; n < PHASE_LEN; n++) begin
                // halfway through, let the pipe run dry before going on
                if (n == PHASE_LEN / 2) settle();

                pick = $urandom_range(0, 99);
                ch   = 8'($urandom_range(0, 255));
                col  = 7'($urandom_range(0, 127));
                row  = 6'($urandom_range(0, 63));
                if (pick < 60) begin
                    // mostly text with line control; form feed kept rare,
                    // it sweeps the whole store
                    op   = OP_PUT;
                    pick = $urandom_range(0, 99);
                    if (pick < 70) begin
                        if (ch == CH_FF) ch = 8'h46;
                    end else if (pick < 80) begin
                        ch = CH_LF;
                    end else if (pick < 84) begin
                        ch = CH_CR;
                    end else if (pick < 90) begin
                        ch = CH_TAB;
                    end else if (pick < 93) begin
                        ch = CH_BELL;
                    end else if (pick < 95) begin
                        ch = CH_BS;
                    end else if (pick < 97) begin
                        ch = CH_VT;
                    end else if (pick < 98) begin
                        ch = CH_FF;
                    end else if (ch == CH_FF) begin
                        ch = 8'h2E;
                    end
                end else if (pick < 97) begin
                    // reads and cursor moves land on screen most of the time
                    op = (pick < 85) ? OP_READ : OP_SET;
                    if ($urandom_range(0, 4) != 0) begin
                        col = 7'($urandom_range(0, board.eff_cols() - 1));
                        row = 6'($urandom_range(0, board.eff_rows() - 1));
                        if (op == OP_READ && $urandom_range(0, 1) == 1) begin
                            row = 6'(board.cur_line);
                        end
                    end
                end else begin
                    op = OP_NONE;
                end
                send_item(op, ch, col, row);
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (board.awaited.size() != 0) board.report_mismatch("results never arrived");

        if (board.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
